// File: hw/rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants of the detector sum packetizer
// Item and command/status structs, packet header bytes and packet lengths.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int NUM_CH   = 8;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int MAP_W    = NUM_CH * CH_W;
    localparam int IDENT_W  = 64;
    localparam int TEMP_W   = 12;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 64;
    localparam int POS_W    = 5;
    localparam int SUB_W    = 2;

    localparam logic [MAP_W-1:0] CHANNEL_MAP_RESET = 24'hFAC688;

    // Register select taken from paddr[3]
    localparam logic REG_CHANNEL_MAP = 1'b0;
    localparam logic REG_BOARD_IDENT = 1'b1;

    localparam logic [7:0] RES_HDR0  = 8'd253;
    localparam logic [7:0] RES_HDR1  = 8'd252;
    localparam logic [7:0] STAT_HDR0 = 8'd239;
    localparam logic [7:0] STAT_HDR1 = 8'd238;
    localparam logic [7:0] FW_VER0   = 8'd0;
    localparam logic [7:0] FW_VER1   = 8'd3;

    localparam logic [POS_W-1:0] FIRST_DATA_POS = 5'd3;
    localparam logic [POS_W-1:0] STAT_LAST_POS  = 5'd19;
    localparam logic [POS_W-1:0] RES_LAST_POS   = 5'd27;
    localparam logic [SUB_W-1:0] SUB_LAST       = 2'd2;

    typedef struct packed {
        logic                                req_type;
        logic                                end_cycle_level;
        logic                                status_select;
        logic [TEMP_W-1:0]                   temp_reading;
        logic [NUM_CH-1:0][SAMPLE_W-1:0]     samples;
    } dsp_item_t;

    typedef struct packed {
        logic             capture;
        logic             pin_update;
        logic             clear_discard;
        logic             acc_en;
        logic             emit;
        logic             finish;
        logic             is_status;
        logic [CH_W-1:0]  idx;
        logic [SUB_W-1:0] sub;
        logic [POS_W-1:0] pos;
    } dsp_cmd_t;

    typedef struct packed {
        logic req_type;
        logic edge_seen;
        logic discard;
        logic status_sel;
        logic out_free;
    } dsp_stat_t;

endpackage

// File: hw/rtl/dsp_if.sv
// ----------------------------------------------------------------------------
// dsp_if: stream channels of the detector sum packetizer
// Request channel (sample sets and pin polls) and packet byte channel.
// ----------------------------------------------------------------------------
interface dsp_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic               end_cycle_level;
    logic               status_select;
    logic [11:0]        temp_reading;
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
    logic signed [15:0] sample_ch3;
    logic signed [15:0] sample_ch4;
    logic signed [15:0] sample_ch5;
    logic signed [15:0] sample_ch6;
    logic signed [15:0] sample_ch7;

    modport source (
        output valid, req_type, end_cycle_level, status_select, temp_reading,
        output sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        output sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        input  ready
    );
    modport sink (
        input  valid, req_type, end_cycle_level, status_select, temp_reading,
        input  sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        input  sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        output ready
    );
endinterface

interface dsp_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       packet_last;

    modport source (output valid, packet_byte, packet_last, input ready);
    modport sink   (input valid, packet_byte, packet_last, output ready);
endinterface

// File: hw/rtl/dsp_ctrl.sv
// ----------------------------------------------------------------------------
// dsp_ctrl: sequencer of the detector sum packetizer
// Steps the accumulate pass over the channels and the byte-by-byte emission.
// ----------------------------------------------------------------------------
module dsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output dsp_pkg::dsp_cmd_t cmd,
    input  dsp_pkg::dsp_stat_t stat
);
    import dsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_ACCUM  = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CH_W-1:0]  idx_reg, idx_next;
    logic [SUB_W-1:0] sub_reg, sub_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             status_reg, status_next;
    logic [POS_W-1:0] last_pos;

    assign last_pos  = status_reg ? STAT_LAST_POS : RES_LAST_POS;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sub_next      = sub_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        cmd           = '0;
        cmd.idx       = idx_reg;
        cmd.sub       = sub_reg;
        cmd.pos       = pos_reg;
        cmd.is_status = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                idx_next = '0;
                sub_next = '0;
                pos_next = '0;
                if (!stat.req_type)
                begin
                    if (stat.discard)
                    begin
                        cmd.clear_discard = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ACCUM;
                    end
                end
                else
                begin
                    cmd.pin_update = 1'b1;
                    if (stat.edge_seen)
                    begin
                        status_next = stat.status_sel;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACCUM:
            begin
                cmd.acc_en = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == CH_W'(NUM_CH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    // advance byte-in-sum and slot once past the header
                    if (pos_reg >= FIRST_DATA_POS)
                    begin
                        if (sub_reg == SUB_LAST)
                        begin
                            sub_next = '0;
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            sub_next = sub_reg + 1'b1;
                        end
                    end
                    if (pos_reg == last_pos)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            sub_reg    <= '0;
            pos_reg    <= '0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            sub_reg    <= sub_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: hw/rtl/dsp_datapath.sv
// ----------------------------------------------------------------------------
// dsp_datapath: accumulators, cycle state and packet byte register
// Shared 24-bit adder for the sums, byte selection and output register.
// ----------------------------------------------------------------------------
module dsp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dsp_pkg::dsp_item_t             item,
    input  dsp_pkg::dsp_cmd_t              cmd,
    output dsp_pkg::dsp_stat_t             stat,
    input  logic [dsp_pkg::MAP_W-1:0]      channel_map,
    input  logic [dsp_pkg::IDENT_W-1:0]    board_ident,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     packet_byte,
    output logic                           packet_last
);
    import dsp_pkg::*;

    localparam logic [POS_W-1:0] POS_HDR0     = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1     = 5'd1;
    localparam logic [POS_W-1:0] POS_COUNT    = 5'd2;
    localparam logic [POS_W-1:0] POS_BOARD_HI = 5'd10;
    localparam logic [POS_W-1:0] POS_VER0     = 5'd11;
    localparam logic [POS_W-1:0] POS_VER1     = 5'd12;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 5'd13;
    localparam logic [POS_W-1:0] POS_TEMP_HI  = 5'd14;
    localparam logic [POS_W-1:0] POS_SUM_HI   = 5'd26;

    dsp_item_t         item_reg;
    logic [SUM_W-1:0]  sums_reg [NUM_CH];
    logic              prev_reg;
    logic              discard_reg;
    logic [7:0]        cycle_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [CH_W-1:0]     map_idx;
    logic [CH_W-1:0]     sum_idx;
    logic [SUM_W-1:0]    sum_rd;
    logic [SAMPLE_W-1:0] sample_sel;
    logic [SUM_W-1:0]    sum_add;
    logic [2:0]          board_k;
    logic [7:0]          byte_val;

    assign map_idx    = channel_map[CH_W*cmd.idx +: CH_W];
    assign sum_idx    = cmd.emit ? map_idx : cmd.idx;
    assign sum_rd     = sums_reg[sum_idx];
    assign sample_sel = item_reg.samples[cmd.idx];
    assign sum_add    = sum_rd + {{(SUM_W-SAMPLE_W){sample_sel[SAMPLE_W-1]}}, sample_sel};
    assign board_k    = 3'(cmd.pos - FIRST_DATA_POS);

    assign stat.req_type   = item_reg.req_type;
    assign stat.edge_seen  = item_reg.end_cycle_level & ~prev_reg;
    assign stat.discard    = discard_reg;
    assign stat.status_sel = item_reg.status_select;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign packet_byte = out_byte_reg;
    assign packet_last = out_last_reg;

    always_comb
    begin
        byte_val = '0;
        if (cmd.is_status)
        begin
            case (cmd.pos) inside
                POS_HDR0:                       byte_val = STAT_HDR0;
                POS_HDR1:                       byte_val = STAT_HDR1;
                POS_COUNT:                      byte_val = cycle_reg;
                [FIRST_DATA_POS:POS_BOARD_HI]:  byte_val = board_ident[8*board_k +: 8];
                POS_VER0:                       byte_val = FW_VER0;
                POS_VER1:                       byte_val = FW_VER1;
                POS_TEMP_LO:                    byte_val = temp_reg[7:0];
                POS_TEMP_HI:                    byte_val = {4'b0, temp_reg[TEMP_W-1:8]};
                default:                        byte_val = '0;
            endcase
        end
        else
        begin
            case (cmd.pos) inside
                POS_HDR0:                     byte_val = RES_HDR0;
                POS_HDR1:                     byte_val = RES_HDR1;
                POS_COUNT:                    byte_val = cycle_reg;
                [FIRST_DATA_POS:POS_SUM_HI]:  byte_val = sum_rd[8*cmd.sub +: 8];
                default:                      byte_val = '0;
            endcase
        end
    end

    // Payload capture and output byte load
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                sums_reg[i] <= '0;
            end
            prev_reg      <= 1'b0;
            discard_reg   <= 1'b1;
            cycle_reg     <= '0;
            temp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                sums_reg[sum_idx] <= sum_add;
            end
            else if (cmd.emit && !cmd.is_status && cmd.sub == SUB_LAST)
            begin
                // clear the sum once its top byte goes out
                sums_reg[sum_idx] <= '0;
            end
            if (cmd.pin_update)
            begin
                prev_reg <= item_reg.end_cycle_level;
            end
            if (cmd.clear_discard)
            begin
                discard_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                discard_reg <= 1'b1;
                cycle_reg   <= cycle_reg + 1'b1;
                if (cmd.is_status)
                begin
                    temp_reg <= item_reg.temp_reading;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("byte loaded over an untaken byte");

    a_finish_arms_discard: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> discard_reg)
        else $error("discard not armed after packet");

    a_finish_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (cycle_reg == 8'($past(cycle_reg) + 8'd1)))
        else $error("cycle count did not advance after packet");

    a_last_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_last_reg == $past(cmd.finish)))
        else $error("packet_last does not match end of packet");

endmodule

// File: hw/rtl/detector_sum_packetizer_top.sv
// ----------------------------------------------------------------------------
// detector_sum_packetizer_top: detector sample summer and packet builder
// Sums eight signed sample channels and sends status or results packets.
// ----------------------------------------------------------------------------
//
//   channel  | kind        | transfer contents
//   ---------+-------------+-----------------------------------------------
//   req      | stream in   | sample set (8 x s16) or pin poll (level, select,
//            |             | temperature)
//   pkt      | stream out  | one packet byte plus last-byte flag
//   APB      | config      | 0x0 channel_map (24 b), 0x8 board_ident (64 b)
//
// Flow: a sample set is captured, decided, then passed one channel per
// cycle through the single shared 24-bit adder. A pin poll without a
// rising edge returns to idle after the decide step. A rising edge emits 20 (status) or 28 (results)
// bytes, one per cycle out of the byte register while the sink takes them.
// Reset: asynchronous, clears sums, cycle count and temperature, arms discard.
// Stalls: pkt.ready low holds the byte register and freezes emission; req is
// not taken until the current request and its packet bytes are loaded.
//
module detector_sum_packetizer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [dsp_pkg::DATA_W-1:0]    pwdata,
    output logic [dsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    dsp_req_if.sink                       req,
    dsp_pkt_if.source                     pkt
);
    import dsp_pkg::*;

    logic [MAP_W-1:0]   channel_map_reg;
    logic [IDENT_W-1:0] board_ident_reg;
    logic               cfg_write;
    logic               reg_sel;

    dsp_item_t item;
    dsp_cmd_t  cmd;
    dsp_stat_t stat;

    // Configuration: registers decode on one address bit, 8-byte spacing.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_CHANNEL_MAP: prdata = {{(DATA_W-MAP_W){1'b0}}, channel_map_reg};
            REG_BOARD_IDENT: prdata = board_ident_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_map_reg <= CHANNEL_MAP_RESET;
            board_ident_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_CHANNEL_MAP: channel_map_reg <= pwdata[MAP_W-1:0];
                REG_BOARD_IDENT: board_ident_reg <= pwdata;
                default:         board_ident_reg <= board_ident_reg;
            endcase
        end
    end

    // Gather the request fields into one item word for capture.
    assign item.req_type        = req.req_type;
    assign item.end_cycle_level = req.end_cycle_level;
    assign item.status_select   = req.status_select;
    assign item.temp_reading    = req.temp_reading;
    assign item.samples[0]      = req.sample_ch0;
    assign item.samples[1]      = req.sample_ch1;
    assign item.samples[2]      = req.sample_ch2;
    assign item.samples[3]      = req.sample_ch3;
    assign item.samples[4]      = req.sample_ch4;
    assign item.samples[5]      = req.sample_ch5;
    assign item.samples[6]      = req.sample_ch6;
    assign item.samples[7]      = req.sample_ch7;

    // Sequencer: owns the request handshake and steps through the work.
    dsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: sums, per-cycle state and the outgoing byte register.
    dsp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .stat        (stat),
        .channel_map (channel_map_reg),
        .board_ident (board_ident_reg),
        .out_valid   (pkt.valid),
        .out_ready   (pkt.ready),
        .packet_byte (pkt.packet_byte),
        .packet_last (pkt.packet_last)
    );

endmodule

// File: tb/dsp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_tb_pkg: request kinds shared by the packetizer testbench
// Names the two kinds of request transfer so that no file uses bare codes.
// ----------------------------------------------------------------------------
package dsp_tb_pkg;

    typedef enum logic {
        REQ_SAMPLES  = 1'b0,
        REQ_PIN_POLL = 1'b1
    } req_kind_t;

endpackage

// File: tb/dsp_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_packet_checker: packet predictor and byte comparator
// Snoops register writes and request transfers, builds the expected packet
// bytes and compares each byte transfer against the oldest one.
// ----------------------------------------------------------------------------
module dsp_packet_checker
    import dsp_pkg::*;
    import dsp_tb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    dsp_req_if                req_mon,
    dsp_pkt_if                pkt_mon,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pkt_byte_t;

    pkt_byte_t          expected_bytes[$];
    logic [SUM_W-1:0]   ch_sums [NUM_CH];
    logic [MAP_W-1:0]   send_order;
    logic [IDENT_W-1:0] ident_shadow;
    logic               level_seen;
    logic               drop_next;
    logic [7:0]         pkt_count;
    logic [TEMP_W-1:0]  temp_held;

    function automatic void expect_byte(input logic [7:0] data, input logic last);
        expected_bytes.push_back({data, last});
    endfunction

    function automatic void absorb_request(input dsp_item_t it);
        int               k;
        logic [CH_W-1:0]  slot_ch;
        logic [SUM_W-1:0] slot_sum;
        if (it.req_type == REQ_SAMPLES)
        begin
            if (drop_next)
                drop_next = 1'b0;
            else
                for (k = 0; k < NUM_CH; k++)
                    ch_sums[k] = ch_sums[k] +
                        {{(SUM_W-SAMPLE_W){it.samples[k][SAMPLE_W-1]}}, it.samples[k]};
            return;
        end
        // only a low-to-high level change makes a packet
        if (!it.end_cycle_level || level_seen)
        begin
            level_seen = it.end_cycle_level;
            return;
        end
        level_seen = 1'b1;
        if (it.status_select)
        begin
            expect_byte(STAT_HDR0, 1'b0);
            expect_byte(STAT_HDR1, 1'b0);
            expect_byte(pkt_count, 1'b0);
            for (k = 0; k < 8; k++)
                expect_byte(ident_shadow[8*k +: 8], 1'b0);
            expect_byte(FW_VER0, 1'b0);
            expect_byte(FW_VER1, 1'b0);
            expect_byte(temp_held[7:0], 1'b0);
            expect_byte({4'h0, temp_held[11:8]}, 1'b0);
            for (k = 0; k < 5; k++)
                expect_byte(8'h00, k == 4);
            temp_held = it.temp_reading;
        end
        else
        begin
            expect_byte(RES_HDR0, 1'b0);
            expect_byte(RES_HDR1, 1'b0);
            expect_byte(pkt_count, 1'b0);
            // clear on send: a repeated slot reads back zero
            for (k = 0; k < NUM_CH; k++)
            begin
                slot_ch  = send_order[CH_W*k +: CH_W];
                slot_sum = ch_sums[slot_ch];
                expect_byte(slot_sum[7:0], 1'b0);
                expect_byte(slot_sum[15:8], 1'b0);
                expect_byte(slot_sum[23:16], 1'b0);
                ch_sums[slot_ch] = '0;
            end
            expect_byte(8'h00, 1'b1);
        end
        pkt_count = pkt_count + 8'd1;
        drop_next = 1'b1;
    endfunction

    function automatic void compare_byte(input logic [7:0] data, input logic last);
        pkt_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            $display("%0t: packet byte 0x%02h (last %0b) arrived with none expected",
                     $time, data, last);
            fail_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (data !== want.data)
        begin
            $display("%0t: packet_byte expected 0x%02h, actual 0x%02h",
                     $time, want.data, data);
            fail_count++;
        end
        if (last !== want.last)
        begin
            $display("%0t: packet_last expected %0b, actual %0b", $time, want.last, last);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        dsp_item_t it;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CH; k++)
                ch_sums[k] = '0;
            send_order   = CHANNEL_MAP_RESET;
            ident_shadow = '0;
            level_seen   = 1'b0;
            drop_next    = 1'b1;
            pkt_count    = '0;
            temp_held    = '0;
            expected_bytes.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_BOARD_IDENT)
                    ident_shadow = pwdata;
                else
                    send_order = pwdata[MAP_W-1:0];
            end
            if (pkt_mon.valid && pkt_mon.ready)
                compare_byte(pkt_mon.packet_byte, pkt_mon.packet_last);
            if (req_mon.valid && req_mon.ready)
            begin
                it.req_type        = req_mon.req_type;
                it.end_cycle_level = req_mon.end_cycle_level;
                it.status_select   = req_mon.status_select;
                it.temp_reading    = req_mon.temp_reading;
                it.samples = {req_mon.sample_ch7, req_mon.sample_ch6, req_mon.sample_ch5,
                              req_mon.sample_ch4, req_mon.sample_ch3, req_mon.sample_ch2,
                              req_mon.sample_ch1, req_mon.sample_ch0};
                absorb_request(it);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: detector sum packetizer testbench
// Drives sample sets and pin polls with random gaps, stalls the packet sink
// at random and through one long hold-off, steps the registers through
// several settings, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
    import dsp_pkg::*;
    import dsp_tb_pkg::*;

    localparam int CLK_HIGH_NS      = 6;
    localparam int CLK_LOW_NS       = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int MAX_WAIT         = 18;
    // a sample set keeps the block busy but emits nothing
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 800;
    localparam int LIMIT_NS         = 10_000_000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // transfer seen at the last rising edge, read back at the falling edge
    logic req_xfer;
    logic pkt_xfer;

    logic hold_wanted;
    int   items_sent;
    int   fail_count;
    int   pending;

    dsp_req_if req_ch();
    dsp_pkt_if pkt_ch();

    detector_sum_packetizer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .pkt     (pkt_ch)
    );

    dsp_packet_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .req_mon    (req_ch),
        .pkt_mon    (pkt_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_LOW_NS);
        clk = 1'b1;
        #(CLK_HIGH_NS);
    end

    always @(posedge clk)
    begin
        req_xfer <= rst_n && req_ch.valid && req_ch.ready;
        pkt_xfer <= rst_n && pkt_ch.valid && pkt_ch.ready;
    end

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Favor the extremes and all-ones so that sums wrap often
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom();
        case (r[31:29])
            3'd0:    return 16'h7FFF;
            3'd1:    return 16'h8000;
            3'd2:    return 16'hFFFF;
            default: return r[15:0];
        endcase
    endfunction

    // Sample set; the pin fields carry junk that the block must ignore
    function automatic dsp_item_t random_samples();
        dsp_item_t   it;
        logic [31:0] r;
        int          k;
        r = $urandom();
        it.req_type        = REQ_SAMPLES;
        it.end_cycle_level = r[0];
        it.status_select   = r[1];
        it.temp_reading    = r[13:2];
        for (k = 0; k < NUM_CH; k++)
            it.samples[k] = pick_sample();
        return it;
    endfunction

    function automatic dsp_item_t uniform_samples(input logic [SAMPLE_W-1:0] value);
        dsp_item_t it;
        int        k;
        it = random_samples();
        for (k = 0; k < NUM_CH; k++)
            it.samples[k] = value;
        return it;
    endfunction

    // Pin poll; the sample fields carry junk that the block must ignore
    function automatic dsp_item_t pin_poll(input logic level, input logic sel,
                                           input logic [TEMP_W-1:0] temp);
        dsp_item_t it;
        it.req_type        = REQ_PIN_POLL;
        it.end_cycle_level = level;
        it.status_select   = sel;
        it.temp_reading    = temp;
        it.samples         = {$urandom(), $urandom(), $urandom(), $urandom()};
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transfer per call, entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic offer(input dsp_item_t it);
        int gap;
        // every fourth stretch of 16 items goes back to back
        gap = ((items_sent / 16) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.req_type        <= it.req_type;
        req_ch.end_cycle_level <= it.end_cycle_level;
        req_ch.status_select   <= it.status_select;
        req_ch.temp_reading    <= it.temp_reading;
        req_ch.sample_ch0      <= it.samples[0];
        req_ch.sample_ch1      <= it.samples[1];
        req_ch.sample_ch2      <= it.samples[2];
        req_ch.sample_ch3      <= it.samples[3];
        req_ch.sample_ch4      <= it.samples[4];
        req_ch.sample_ch5      <= it.samples[5];
        req_ch.sample_ch6      <= it.samples[6];
        req_ch.sample_ch7      <= it.samples[7];
        req_ch.valid           <= 1'b1;
        // hold the item until the block takes it
        do
            @(negedge clk);
        while (!req_xfer);
        items_sent++;
    endtask

    // Drop valid, wait for every expected byte, then let a trailing
    // sample set finish inside the block
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: setup phase, then access phase until pready
    task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed measurement cycles (level low, a few sample sets,
    // level high); the rest is noise of either kind with any level
    task automatic run_random(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    offer(random_samples());
                else
                    offer(pin_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   12'($urandom_range(0, 4095))));
                left--;
            end
            else
            begin
                offer(pin_poll(1'b0, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095))));
                burst = $urandom_range(0, 4);
                repeat (burst) offer(random_samples());
                offer(pin_poll(1'b1, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095))));
                left -= burst + 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Packet side: random stall before each byte, calm stretches, and one
    // long hold-off on request so that the block backs up into its input
    // ------------------------------------------------------------------
    initial
    begin
        int   stall;
        int   taken;
        logic hold_done;
        taken          = 0;
        hold_done      = 1'b0;
        pkt_ch.ready   = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_wanted && !hold_done)
            begin
                stall     = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if ((taken / 40) % 4 == 3)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                pkt_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pkt_ch.ready <= 1'b1;
            do
                @(negedge clk);
            while (!pkt_xfer);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dsp_item_t it;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_SAMPLES;
        req_ch.end_cycle_level = 1'b0;
        req_ch.status_select   = 1'b0;
        req_ch.temp_reading    = '0;
        req_ch.sample_ch0      = '0;
        req_ch.sample_ch1      = '0;
        req_ch.sample_ch2      = '0;
        req_ch.sample_ch3      = '0;
        req_ch.sample_ch4      = '0;
        req_ch.sample_ch5      = '0;
        req_ch.sample_ch6      = '0;
        req_ch.sample_ch7      = '0;
        hold_wanted            = 1'b0;
        items_sent             = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values.
        // The first sample set after reset is dropped: make it the positive
        // extreme so that a missing drop shows in the sums.
        offer(uniform_samples(16'h7FFF));
        offer(uniform_samples(16'h7FFF));
        offer(uniform_samples(16'h8000));
        it = random_samples();
        it.samples = {16'h1234, 16'h0000, 16'hAAAA, 16'h5555,
                      16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
        offer(it);
        offer(pin_poll(1'b0, 1'b1, 12'hFFF));    // level low: no packet
        offer(pin_poll(1'b1, 1'b0, 12'hFFF));    // rising: results packet
        offer(pin_poll(1'b1, 1'b1, 12'h000));    // still high: no packet
        // sample set with every pin field set: dropped, pin fields ignored
        it = uniform_samples(16'h7FFF);
        it.end_cycle_level = 1'b1;
        it.status_select   = 1'b1;
        it.temp_reading    = 12'hFFF;
        offer(it);
        offer(uniform_samples(16'h8000));
        offer(pin_poll(1'b0, 1'b0, 12'h000));
        offer(pin_poll(1'b1, 1'b1, 12'hFFF));    // status with the reset temperature
        offer(pin_poll(1'b0, 1'b1, 12'h000));
        offer(pin_poll(1'b1, 1'b1, 12'h000));    // status shows the full-scale code
        offer(pin_poll(1'b0, 1'b0, 12'hAAA));
        offer(pin_poll(1'b1, 1'b0, 12'h555));    // results: one negative set summed
        offer(random_samples());
        offer(random_samples());
        offer(random_samples());
        offer(pin_poll(1'b0, 1'b1, 12'h555));
        offer(pin_poll(1'b1, 1'b0, 12'hAAA));
        settle();

        // Every slot names accumulator 0: later slots send zeros, the
        // others keep summing and wrap. Ask for the long hold-off midway.
        write_reg(REG_CHANNEL_MAP, '0);
        write_reg(REG_BOARD_IDENT, '1);
        run_random(15);
        hold_wanted = 1'b1;
        run_random(40);
        settle();

        // Every slot names accumulator 7; junk above the map field
        write_reg(REG_CHANNEL_MAP, {$urandom(), 32'hFFFF_FFFF});
        write_reg(REG_BOARD_IDENT, {$urandom(), $urandom()});
        run_random(50);
        settle();

        // Arbitrary map
        write_reg(REG_CHANNEL_MAP, {$urandom(), $urandom()});
        write_reg(REG_BOARD_IDENT, {$urandom(), $urandom()});
        run_random(50);
        settle();

        // Back to the straight map
        write_reg(REG_CHANNEL_MAP, DATA_W'(CHANNEL_MAP_RESET));
        write_reg(REG_BOARD_IDENT, {$urandom(), $urandom()});
        run_random(35);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("detector_sum_packetizer_top verification clean");
        else
            $display("detector_sum_packetizer_top verification failed");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("detector_sum_packetizer_top verification failed");
        $finish;
    end

endmodule
